/* rtl/spq_pkg.sv */
package spq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int TAG_BITS_DEF = 16;
  localparam int SEV_W        = 8;
  localparam int STAMP_W      = 32;
  localparam int REQ_W        = 2;
  localparam int STATUS_W     = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT    = 2'd0,
    REQ_EXTRACT   = 2'd1,
    REQ_CLEAR     = 2'd2,
    REQ_CLEAR_ALT = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_EXTRACTED = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    RD_ROOT   = 3'd0,
    RD_LAST   = 3'd1,
    RD_PARENT = 3'd2,
    RD_LEFT   = 3'd3,
    RD_RIGHT  = 3'd4
  } rd_sel_t;

  typedef struct packed {
    logic    ld_req;
    logic    clear;
    logic    ins_setup;
    logic    ex_take;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    ld_item;
    logic    set_i0;
    logic    ld_cand;
    logic    upd_cand;
    logic    wr_item;
    logic    wr_parent;
    logic    wr_cand;
    logic    emit;
    status_t emit_status;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic empty;
    logic full;
    logic last_one;
    logic i_zero;
    logic item_wins;
    logic left_in;
    logic right_in;
    logic cand_wins;
  } dp_sts_t;

endpackage

/* rtl/spq_datapath.sv */
module spq_datapath #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spq_pkg::dp_cmd_t              cmd,
  output spq_pkg::dp_sts_t              sts,
  input  logic [spq_pkg::REQ_W-1:0]     in_req_type,
  input  logic [TAG_BITS-1:0]           in_entry_tag,
  input  logic [spq_pkg::SEV_W-1:0]     in_severity,
  output logic                          out_valid,
  output logic [spq_pkg::STATUS_W-1:0]  out_status,
  output logic [TAG_BITS-1:0]           out_served_tag,
  output logic [spq_pkg::SEV_W-1:0]     out_served_severity
);

  localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LW    = IDX_W + 2;
  localparam int SW    = spq_pkg::STAMP_W;
  localparam int VW    = spq_pkg::SEV_W;
  localparam int ENT_W = TAG_BITS + VW + SW;

  logic [ENT_W-1:0]    mem [CAPACITY];
  logic [ENT_W-1:0]    rd_q_r;
  logic [ENT_W-1:0]    item_r, item_nxt;
  logic [ENT_W-1:0]    cand_r, cand_nxt;
  logic [IDX_W-1:0]    cand_idx_r, cand_idx_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SW-1:0]       arr_r, arr_nxt;
  spq_pkg::req_t       req_r;
  logic [TAG_BITS-1:0] tag_in_r;
  logic [VW-1:0]       sev_in_r;
  logic [TAG_BITS-1:0] hold_tag_r;
  logic [VW-1:0]       hold_sev_r;
  logic                out_valid_r;
  logic [spq_pkg::STATUS_W-1:0] out_status_r;
  logic [TAG_BITS-1:0] out_tag_r;
  logic [VW-1:0]       out_sev_r;

  logic [IDX_W-1:0]    parent;
  logic [LW-1:0]       left_w, right_w;
  logic [IDX_W-1:0]    rd_addr;
  logic [ENT_W-1:0]    wr_data;
  logic                wr_en;
  logic [SW-1:0]       new_stamp;
  logic [CNT_W-1:0]    last_idx;

  function automatic logic first(input logic [ENT_W-1:0] a, input logic [ENT_W-1:0] b);
    logic [VW-1:0] sa, sb;
    sa = a[SW +: VW];
    sb = b[SW +: VW];
    if (sa != sb) return sa > sb;
    return a[SW-1:0] < b[SW-1:0];
  endfunction

  assign parent   = (i_r - IDX_W'(1)) >> 1;
  assign left_w   = {1'b0, i_r, 1'b0} + LW'(1);
  assign right_w  = {1'b0, i_r, 1'b0} + LW'(2);
  assign last_idx = count_r - CNT_W'(1);
  assign new_stamp = (count_r == '0) ? '0 : arr_r;

  always_comb begin
    unique case (cmd.rd_sel)
      spq_pkg::RD_ROOT:   rd_addr = '0;
      spq_pkg::RD_LAST:   rd_addr = last_idx[IDX_W-1:0];
      spq_pkg::RD_PARENT: rd_addr = parent;
      spq_pkg::RD_LEFT:   rd_addr = left_w[IDX_W-1:0];
      spq_pkg::RD_RIGHT:  rd_addr = right_w[IDX_W-1:0];
      default:            rd_addr = '0;
    endcase
  end

  assign wr_en   = cmd.wr_item | cmd.wr_parent | cmd.wr_cand;
  assign wr_data = cmd.wr_parent ? rd_q_r : (cmd.wr_cand ? cand_r : item_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[i_r] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_comb begin
    item_nxt     = item_r;
    cand_nxt     = cand_r;
    cand_idx_nxt = cand_idx_r;
    i_nxt        = i_r;
    count_nxt    = count_r;
    arr_nxt      = arr_r;
    if (cmd.clear) begin
      count_nxt = '0;
      arr_nxt   = '0;
    end
    if (cmd.ins_setup) begin
      item_nxt  = {tag_in_r, sev_in_r, new_stamp};
      arr_nxt   = new_stamp + SW'(1);
      count_nxt = count_r + CNT_W'(1);
      i_nxt     = count_r[IDX_W-1:0];
    end
    if (cmd.ex_take) begin
      count_nxt = last_idx;
      if (count_r == CNT_W'(1)) begin
        arr_nxt = '0;
      end
    end
    if (cmd.ld_item) item_nxt = rd_q_r;
    if (cmd.set_i0) i_nxt = '0;
    if (cmd.ld_cand) begin
      cand_nxt     = rd_q_r;
      cand_idx_nxt = left_w[IDX_W-1:0];
    end
    if (cmd.upd_cand && first(rd_q_r, cand_r)) begin
      cand_nxt     = rd_q_r;
      cand_idx_nxt = right_w[IDX_W-1:0];
    end
    if (cmd.wr_parent) i_nxt = parent;
    if (cmd.wr_cand) i_nxt = cand_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      arr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      arr_r       <= arr_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cand_r     <= cand_nxt;
    cand_idx_r <= cand_idx_nxt;
    i_r        <= i_nxt;
    if (cmd.ld_req) begin
      req_r    <= spq_pkg::req_t'(in_req_type);
      tag_in_r <= in_entry_tag;
      sev_in_r <= in_severity;
    end
    if (cmd.ex_take) begin
      hold_tag_r <= rd_q_r[SW+VW +: TAG_BITS];
      hold_sev_r <= rd_q_r[SW +: VW];
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      if (cmd.emit_status == spq_pkg::ST_EXTRACTED) begin
        out_tag_r <= cmd.ex_take ? rd_q_r[SW+VW +: TAG_BITS] : hold_tag_r;
        out_sev_r <= cmd.ex_take ? rd_q_r[SW +: VW] : hold_sev_r;
      end else begin
        out_tag_r <= '0;
        out_sev_r <= '0;
      end
    end
  end

  assign sts.req       = req_r;
  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r == CNT_W'(CAPACITY));
  assign sts.last_one  = (count_r == CNT_W'(1));
  assign sts.i_zero    = (i_r == '0);
  assign sts.item_wins = first(item_r, rd_q_r);
  assign sts.left_in   = (left_w < LW'(count_r));
  assign sts.right_in  = (right_w < LW'(count_r));
  assign sts.cand_wins = first(cand_r, item_r);

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_served_tag      = out_tag_r;
  assign out_served_severity = out_sev_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != spq_pkg::ST_EXTRACTED |-> out_tag_r == '0 && out_sev_r == '0)
    else $error("Served fields are not zero outside an extract.");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == spq_pkg::ST_CLEARED |-> count_r == '0)
    else $error("Queue not empty after a clear.");

endmodule

/* rtl/spq_ctrl.sv */
module spq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  spq_pkg::dp_sts_t sts,
  output spq_pkg::dp_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DISPATCH = 10'b0000000010,
    S_UP_CHK   = 10'b0000000100,
    S_UP_CMP   = 10'b0000001000,
    S_EX_TAKE  = 10'b0000010000,
    S_EX_LAST  = 10'b0000100000,
    S_DN_CHK   = 10'b0001000000,
    S_DN_L     = 10'b0010000000,
    S_DN_R     = 10'b0100000000,
    S_DN_CMP   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = spq_pkg::RD_ROOT;
    cmd.emit_status = spq_pkg::ST_INSERTED;
    state_nxt   = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld_req = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.req)
          spq_pkg::REQ_INSERT: begin
            if (sts.full) begin
              cmd.emit = 1'b1;
              cmd.emit_status = spq_pkg::ST_FULL;
              state_nxt = S_IDLE;
            end else begin
              cmd.ins_setup = 1'b1;
              state_nxt = S_UP_CHK;
            end
          end
          spq_pkg::REQ_EXTRACT: begin
            if (sts.empty) begin
              cmd.emit = 1'b1;
              cmd.emit_status = spq_pkg::ST_EMPTY;
              state_nxt = S_IDLE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = spq_pkg::RD_ROOT;
              state_nxt  = S_EX_TAKE;
            end
          end
          default: begin
            cmd.clear = 1'b1;
            cmd.emit  = 1'b1;
            cmd.emit_status = spq_pkg::ST_CLEARED;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_UP_CHK: begin
        if (sts.i_zero) begin
          cmd.wr_item = 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_status = spq_pkg::ST_INSERTED;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = spq_pkg::RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.item_wins) begin
          cmd.wr_parent = 1'b1;
          state_nxt = S_UP_CHK;
        end else begin
          cmd.wr_item = 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_status = spq_pkg::ST_INSERTED;
          state_nxt = S_IDLE;
        end
      end
      S_EX_TAKE: begin
        cmd.ex_take = 1'b1;
        if (sts.last_one) begin
          cmd.emit = 1'b1;
          cmd.emit_status = spq_pkg::ST_EXTRACTED;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = spq_pkg::RD_LAST;
          state_nxt  = S_EX_LAST;
        end
      end
      S_EX_LAST: begin
        cmd.ld_item = 1'b1;
        cmd.set_i0  = 1'b1;
        state_nxt   = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts.left_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = spq_pkg::RD_LEFT;
          state_nxt  = S_DN_L;
        end else begin
          cmd.wr_item = 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_status = spq_pkg::ST_EXTRACTED;
          state_nxt = S_IDLE;
        end
      end
      S_DN_L: begin
        cmd.ld_cand = 1'b1;
        if (sts.right_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = spq_pkg::RD_RIGHT;
          state_nxt  = S_DN_R;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_R: begin
        cmd.upd_cand = 1'b1;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.cand_wins) begin
          cmd.wr_cand = 1'b1;
          state_nxt = S_DN_CHK;
        end else begin
          cmd.wr_item = 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_status = spq_pkg::ST_EXTRACTED;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* rtl/stable_priority_queue.sv */
// An insert sifts the new entry up from the next free slot; an extract takes the root
// and sifts the last entry down from it. Full, empty and clear requests are answered
// at dispatch. One request is handled at a time; the single-port heap memory and its
// registered read set the cost of each heap level. The receiver cannot stall.
// Reset is synchronous and active low; it empties the queue and restarts the stamp.
module stable_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [spq_pkg::REQ_W-1:0]     in_req_type,
  input  logic [TAG_BITS-1:0]           in_entry_tag,
  input  logic [spq_pkg::SEV_W-1:0]     in_severity,
  output logic                          out_valid,
  output logic [spq_pkg::STATUS_W-1:0]  out_status,
  output logic [TAG_BITS-1:0]           out_served_tag,
  output logic [spq_pkg::SEV_W-1:0]     out_served_severity
);

  spq_pkg::dp_cmd_t cmd;
  spq_pkg::dp_sts_t sts;
  logic             busy_int;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy_int),
    .sts   (sts),
    .cmd   (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_req_type         (in_req_type),
    .in_entry_tag        (in_entry_tag),
    .in_severity         (in_severity),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_served_tag      (out_served_tag),
    .out_served_severity (out_served_severity)
  );

  assign busy = busy_int;

endmodule

/* tb/stable_priority_queue_test.sv */
module stable_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP  = 64;
  localparam int TAGW = 16;

  typedef struct {
    logic [TAGW-1:0]             tag;
    logic [spq_pkg::SEV_W-1:0]   sev;
    logic [spq_pkg::STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct {
    spq_pkg::status_t          status;
    logic [TAGW-1:0]           tag;
    logic [spq_pkg::SEV_W-1:0] sev;
  } answer_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [spq_pkg::REQ_W-1:0]    in_req_type;
  logic [TAGW-1:0]              in_entry_tag;
  logic [spq_pkg::SEV_W-1:0]    in_severity;
  logic                         out_valid;
  logic [spq_pkg::STATUS_W-1:0] out_status;
  logic [TAGW-1:0]              out_served_tag;
  logic [spq_pkg::SEV_W-1:0]    out_served_severity;

  entry_t                      held[$];
  logic [spq_pkg::STAMP_W-1:0] next_stamp;
  answer_t                     awaited[$];
  int                          mismatches;

  stable_priority_queue uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_entry_tag(in_entry_tag), .in_severity(in_severity),
    .out_valid(out_valid), .out_status(out_status), .out_served_tag(out_served_tag),
    .out_served_severity(out_served_severity)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic answer_t serve_request(spq_pkg::req_t req, logic [TAGW-1:0] tag,
                                            logic [spq_pkg::SEV_W-1:0] sev);
    answer_t a;
    entry_t  e;
    int      best;
    a.status = spq_pkg::ST_CLEARED;
    a.tag = '0;
    a.sev = '0;
    if (req == spq_pkg::REQ_INSERT) begin
      if (held.size() >= CAP) begin
        a.status = spq_pkg::ST_FULL;
      end else begin
        if (held.size() == 0) next_stamp = '0;
        e.tag = tag;
        e.sev = sev;
        e.stamp = next_stamp;
        next_stamp = next_stamp + 1;
        held.push_back(e);
        a.status = spq_pkg::ST_INSERTED;
      end
    end else if (req == spq_pkg::REQ_EXTRACT) begin
      if (held.size() == 0) begin
        a.status = spq_pkg::ST_EMPTY;
      end else begin
        best = 0;
        foreach (held[i]) begin
          if (held[i].sev > held[best].sev ||
              (held[i].sev == held[best].sev && held[i].stamp < held[best].stamp))
            best = i;
        end
        a.status = spq_pkg::ST_EXTRACTED;
        a.tag = held[best].tag;
        a.sev = held[best].sev;
        held.delete(best);
        if (held.size() == 0) next_stamp = '0;
      end
    end else begin
      held.delete();
      next_stamp = '0;
    end
    return a;
  endfunction

  task automatic send_request(spq_pkg::req_t req, logic [TAGW-1:0] tag,
                              logic [spq_pkg::SEV_W-1:0] sev);
    int gap;
    start <= 1'b1;
    in_req_type <= req;
    in_entry_tag <= tag;
    in_severity <= sev;
    do @(posedge clk); while (busy);
    awaited.push_back(serve_request(req, tag, sev));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: gap = 0;
      5, 6, 7, 8:    gap = $urandom_range(1, 4);
      default:       gap = $urandom_range(10, 40);
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_valid) begin
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: status %0d tag %h severity %h",
                   out_status, out_served_tag, out_served_severity);
      end else begin
        a = awaited.pop_front();
        if (out_status !== a.status || out_served_tag !== a.tag ||
            out_served_severity !== a.sev) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d/%h/%h, got %0d/%h/%h", a.status, a.tag,
                     a.sev, out_status, out_served_tag, out_served_severity);
        end
      end
    end
  end

  task automatic test_empty_and_extremes();
    send_request(spq_pkg::REQ_EXTRACT, 16'hFFFF, 8'hFF);
    send_request(spq_pkg::REQ_INSERT, 16'h0000, 8'h00);
    send_request(spq_pkg::REQ_INSERT, 16'hFFFF, 8'hFF);
    send_request(spq_pkg::REQ_INSERT, 16'hA5A5, 8'h80);
    repeat (3) send_request(spq_pkg::REQ_EXTRACT, 16'h0, 8'h0);
    send_request(spq_pkg::REQ_EXTRACT, 16'h0, 8'h0);
  endtask

  task automatic test_equal_severity_order();
    for (int i = 0; i < 5; i++)
      send_request(spq_pkg::REQ_INSERT, 16'(16'h1000 + i), 8'h42);
    send_request(spq_pkg::REQ_INSERT, 16'h2000, 8'h43);
    repeat (3) send_request(spq_pkg::REQ_EXTRACT, 16'h0, 8'h0);
    send_request(spq_pkg::REQ_CLEAR_ALT, 16'h5555, 8'h55);
    send_request(spq_pkg::REQ_EXTRACT, 16'h0, 8'h0);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < CAP; i++)
      send_request(spq_pkg::REQ_INSERT, 16'($urandom), 8'($urandom_range(0, 3)));
    send_request(spq_pkg::REQ_INSERT, 16'hBEEF, 8'hFF);
    repeat (4) send_request(spq_pkg::REQ_EXTRACT, 16'h0, 8'h0);
    send_request(spq_pkg::REQ_CLEAR, 16'h0, 8'h0);
  endtask

  task automatic test_random_traffic(int count);
    int            fill_bias;
    int            pick;
    spq_pkg::req_t req;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) fill_bias = $urandom_range(20, 90);
      pick = $urandom_range(0, 99);
      if (pick < 2)                  req = spq_pkg::REQ_CLEAR;
      else if (pick < 3)             req = spq_pkg::REQ_CLEAR_ALT;
      else if (pick < 3 + fill_bias) req = spq_pkg::REQ_INSERT;
      else                           req = spq_pkg::REQ_EXTRACT;
      send_request(req, 16'($urandom),
                   ($urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 3))));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = '0;
    in_entry_tag = '0;
    in_severity = '0;
    mismatches = 0;
    next_stamp = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_extremes();
    test_equal_severity_order();
    test_full_queue();
    test_random_traffic(1750);
    start <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
